@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Types, codes and helpers shared by the bitmap block allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int WORD_BITS = 64;
  localparam int POS_W     = 6;
  localparam int BLOCK_W   = 10;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_SCAN    = 5'b00100,
    ST_MODIFY  = 5'b01000,
    ST_RESPOND = 5'b10000
  } state_t;

  // block 0 of a word is its most significant bit
  function automatic logic [WORD_BITS-1:0] word_mask(input logic [POS_W-1:0] pos);
    word_mask = {1'b1, {(WORD_BITS-1){1'b0}}} >> pos;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bba_if.sv @@
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [9:0] block_index;

  modport source (output valid, output action, output block_index, input ready);
  modport sink   (input valid, input action, input block_index, output ready);
endinterface

interface bba_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [9:0] granted_block;

  modport source (output valid, output status, output granted_block, input ready);
  modport sink   (input valid, input status, input granted_block, output ready);
endinterface

`default_nettype wire

@@ rtl/bba_ffs.sv @@
// ----------------------------------------------------------------------------
// bba_ffs
// Finds the lowest-numbered free block (highest set bit) in one map word.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ffs (
  input  logic [bba_pkg::WORD_BITS-1:0] word,
  output logic                          found,
  output logic [bba_pkg::POS_W-1:0]     pos
);
  import bba_pkg::*;

  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (word[i]) begin
        pos = POS_W'(WORD_BITS - 1 - i);
      end
    end
  end

  assign found = |word;

endmodule

`default_nettype wire

@@ rtl/bba_map.sv @@
// ----------------------------------------------------------------------------
// bba_map
// Free map storage: one write and one registered read per cycle, with a
// sweep after reset that marks every block free.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_map #(
  parameter int MAP_WORDS = 16,
  parameter int AW        = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [bba_pkg::WORD_BITS-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [bba_pkg::WORD_BITS-1:0] wr_data,
  output logic                          busy
);
  import bba_pkg::*;

  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [AW-1:0]        clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == LAST_WORD) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '1;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bitmap_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a free map, one 64-bit word scanned a cycle.
// ----------------------------------------------------------------------------
// Allocate: accept, a scan of up to MAP_WORDS words in turn, respond.
// Free: accept, read-modify-write, respond; beyond the map: accept, respond.
// Throughput: one request at a time; a new request is taken once the
//   previous result sits in the output register.
// Reset: a sweep over all MAP_WORDS words marks all blocks free; no request is
//   accepted until it ends.
`default_nettype none

module bitmap_block_allocator_core #(
  parameter int MAP_WORDS = 16
) (
  input  logic      clk,
  input  logic      rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);
  import bba_pkg::*;

  localparam int            AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [10:0]   NUM_WORDS = 11'(MAP_WORDS);

  state_t               state;
  logic [AW-1:0]        ptr;
  logic [POS_W-1:0]     bit_pos;
  logic                 res_status;
  logic [BLOCK_W-1:0]   res_granted;
  logic                 out_valid;
  logic                 out_status;
  logic [BLOCK_W-1:0]   out_granted;

  logic                 map_rd_en;
  logic [AW-1:0]        map_rd_addr;
  logic [WORD_BITS-1:0] map_rd_data;
  logic                 map_wr_en;
  logic [AW-1:0]        map_wr_addr;
  logic [WORD_BITS-1:0] map_wr_data;
  logic                 map_busy;

  logic                 ffs_found;
  logic [POS_W-1:0]     ffs_pos;

  logic                 accept;
  logic [10:0]          free_word;
  logic                 free_in_range;
  logic [15:0]          blk_num;

  bba_map #(
    .MAP_WORDS (MAP_WORDS),
    .AW        (AW)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .busy    (map_busy)
  );

  bba_ffs u_ffs (
    .word  (map_rd_data),
    .found (ffs_found),
    .pos   (ffs_pos)
  );

  assign req.ready         = (state == ST_IDLE);
  assign accept            = req.valid && req.ready;
  assign free_word         = {7'b0, req.block_index[9:6]};
  assign free_in_range     = (free_word < NUM_WORDS);
  assign blk_num           = 16'({ptr, ffs_pos});

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.granted_block = out_granted;

  always_comb begin
    map_rd_en   = 1'b0;
    map_rd_addr = ptr;
    map_wr_en   = 1'b0;
    map_wr_addr = ptr;
    map_wr_data = map_rd_data;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.action == ACT_FREE) begin
            map_rd_en   = free_in_range;
            map_rd_addr = AW'(free_word);
          end else begin
            map_rd_en   = 1'b1;
            map_rd_addr = '0;
          end
        end
      end
      ST_SCAN: begin
        if (ffs_found) begin
          map_wr_en   = 1'b1;
          map_wr_data = map_rd_data & ~word_mask(ffs_pos);
        end else if (ptr != LAST_WORD) begin
          map_rd_en   = 1'b1;
          map_rd_addr = ptr + 1'b1;
        end
      end
      ST_MODIFY: begin
        map_wr_en   = 1'b1;
        map_wr_data = map_rd_data | word_mask(bit_pos);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != ST_RESPOND) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (!map_busy) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_status  <= STATUS_OK;
            res_granted <= '0;
            if (req.action == ACT_FREE) begin
              ptr     <= AW'(free_word);
              bit_pos <= req.block_index[5:0];
              state   <= free_in_range ? ST_MODIFY : ST_RESPOND;
            end else begin
              ptr   <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (ffs_found) begin
            res_granted <= blk_num[BLOCK_W-1:0];
            state       <= ST_RESPOND;
          end else if (ptr == LAST_WORD) begin
            res_status <= STATUS_FULL;
            state      <= ST_RESPOND;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        ST_MODIFY: begin
          state <= ST_RESPOND;
        end
        ST_RESPOND: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            out_granted <= res_granted;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while a previous one is in flight");

  a_rsp_from_respond: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_RESPOND))
    else $error("result raised outside the respond step");

  a_write_in_update: assert property (@(posedge clk) disable iff (rst)
    map_wr_en |-> (state == ST_SCAN || state == ST_MODIFY))
    else $error("map written outside an update step");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(map_wr_en && map_rd_en))
    else $error("map read and written in the same cycle");

  a_no_request_in_clear: assert property (@(posedge clk) disable iff (rst)
    map_busy |-> !req.ready)
    else $error("request accepted during the clearing sweep");

endmodule

`default_nettype wire

@@ tb/bba_grant_checker.sv @@
// ----------------------------------------------------------------------------
// bba_grant_checker
// Watches the request and result channels of the block allocator, keeps its
// own free map, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module bba_grant_checker #(
  parameter int MAP_WORDS = 16
) (
  input  logic clk,
  input  logic rst,
  bba_req_if   req,
  bba_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  typedef struct packed {
    logic               status;
    logic [BLOCK_W-1:0] granted_block;
  } grant_t;

  logic [WORD_BITS-1:0] free_bits [MAP_WORDS];
  grant_t               expected_grants [$];
  int                   reported;

  // first fit: block b is bit 63-(b mod 64) of word b/64
  function automatic grant_t serve_request(input logic act, input logic [BLOCK_W-1:0] idx);
    grant_t g;
    int     w;
    int     p;
    int     blk;
    bit     found;
    g.status        = STATUS_OK;
    g.granted_block = '0;
    found           = 1'b0;
    blk             = int'(idx);
    if (act == ACT_ALLOC) begin
      for (w = 0; w < MAP_WORDS && !found; w++) begin
        for (p = 0; p < WORD_BITS && !found; p++) begin
          if (free_bits[w][WORD_BITS-1-p]) begin
            found                     = 1'b1;
            free_bits[w][WORD_BITS-1-p] = 1'b0;
            g.granted_block           = BLOCK_W'(w * WORD_BITS + p);
          end
        end
      end
      if (!found) g.status = STATUS_FULL;
    end else if (blk / WORD_BITS < MAP_WORDS) begin
      free_bits[blk / WORD_BITS][WORD_BITS-1-(blk % WORD_BITS)] = 1'b1;
    end
    return g;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
    reported    = 0;
  end

  always @(posedge clk) begin : watch
    grant_t want;
    grant_t got;
    if (rst) begin
      foreach (free_bits[w]) free_bits[w] = '1;
      expected_grants.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.status        = rsp.status;
        got.granted_block = rsp.granted_block;
        if (expected_grants.size() == 0) begin
          mismatches++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected result status=%0d granted_block=%0d",
                     $realtime, got.status, got.granted_block);
          end
        end else begin
          want = expected_grants.pop_front();
          if (got.status !== want.status || got.granted_block !== want.granted_block) begin
            mismatches++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch: exp status=%0d block=%0d, got status=%0d block=%0d",
                       $realtime, want.status, want.granted_block,
                       got.status, got.granted_block);
            end
          end
        end
      end
      if (req.valid && req.ready)
        expected_grants.push_back(serve_request(req.action, req.block_index));
    end
    outstanding = expected_grants.size();
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free requests into the block allocator under varying
// sender and receiver idling, and reports the verdict from the checker's
// mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int MAP_WORDS   = 16;
  localparam int MAP_BLOCKS  = MAP_WORDS * WORD_BITS;
  localparam int CYCLE_LIMIT = 500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   mismatches;
  int   outstanding;
  int   req_idle_pct;
  int   rsp_idle_pct;
  int   fill_level;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  bitmap_block_allocator_core #(.MAP_WORDS(MAP_WORDS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bba_grant_checker #(.MAP_WORDS(MAP_WORDS)) grant_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[bitmap_block_allocator_core] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
  end

  // hold the request until accepted; return on the following falling edge
  task automatic issue(input logic act, input logic [BLOCK_W-1:0] idx);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.action      <= act;
    req_ch.block_index <= idx;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    @(negedge clk);
    if (act == ACT_ALLOC) begin
      if (fill_level < MAP_BLOCKS) fill_level++;
    end else if (int'(idx) < fill_level) begin
      fill_level--;
    end
  endtask

  task automatic issue_random(input int alloc_pct);
    int hi;
    if ($urandom_range(0, 99) < alloc_pct) begin
      issue(ACT_ALLOC, BLOCK_W'($urandom_range(0, MAP_BLOCKS - 1)));
    end else if ($urandom_range(0, 99) < 80) begin
      hi = (fill_level + 7 > MAP_BLOCKS - 1) ? MAP_BLOCKS - 1 : fill_level + 7;
      issue(ACT_FREE, BLOCK_W'($urandom_range(0, hi)));
    end else begin
      issue(ACT_FREE, BLOCK_W'($urandom_range(0, MAP_BLOCKS - 1)));
    end
  endtask

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.action      = ACT_ALLOC;
    req_ch.block_index = '0;
    rsp_ch.ready       = 1'b0;
    fill_level         = 0;
    req_idle_pct       = 26;
    rsp_idle_pct       = 62;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // free of free blocks, ignored index on allocate, reuse of freed blocks
    issue(ACT_FREE,  10'd0);
    issue(ACT_FREE,  10'd1023);
    issue(ACT_ALLOC, 10'd0);
    issue(ACT_ALLOC, 10'h3FF);
    issue(ACT_ALLOC, 10'h2AA);
    issue(ACT_ALLOC, 10'h155);
    issue(ACT_FREE,  10'd2);
    issue(ACT_ALLOC, 10'd0);
    issue(ACT_FREE,  10'd0);
    issue(ACT_FREE,  10'd3);
    issue(ACT_ALLOC, 10'd0);
    issue(ACT_ALLOC, 10'd0);
    issue(ACT_ALLOC, 10'd0);
    issue(ACT_FREE,  10'd1);
    issue(ACT_FREE,  10'd1);
    issue(ACT_ALLOC, 10'd0);
    issue(ACT_FREE,  10'd64);
    issue(ACT_FREE,  10'd63);
    issue(ACT_ALLOC, 10'd0);
    issue(ACT_FREE,  10'd1023);
    fill_level = 6;

    repeat (270) issue_random(60);

    req_idle_pct = 62;
    rsp_idle_pct = 26;
    repeat (270) issue_random(55);

    req_idle_pct = 0;
    rsp_idle_pct = 0;
    repeat (290) issue_random(50);

    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2 * MAP_WORDS + 8) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("[bitmap_block_allocator_core] OK");
    end else begin
      $display("[bitmap_block_allocator_core] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_ffs.sv
rtl/bba_map.sv
rtl/bitmap_block_allocator_core.sv
tb/bba_grant_checker.sv
tb/testbench.sv
